>>> hw/rtl/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants for the Fenwick tree rank/select block.
// ----------------------------------------------------------------------------
package fts_pkg;

	localparam int INDEX_BITS  = 10;
	localparam int ADDR_W      = INDEX_BITS + 1;
	localparam int WALK_W      = ADDR_W + 1;
	localparam int TABLE_DEPTH = (1 << INDEX_BITS) + 1;
	localparam int SIZE_CAP    = 1 << INDEX_BITS;

	localparam int DATA_W  = 32;
	localparam int DELTA_W = 16;
	localparam int SIZE_W  = 11;
	localparam int TOP_W   = 4;
	localparam int PADDR_W = 3;

	localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = SIZE_W'(1024);
	localparam logic [TOP_W-1:0]  TOP_BIT_RST     = TOP_W'(10);

	// register index, taken from paddr[2]
	localparam logic REG_ACTIVE_SIZE = 1'b0;
	localparam logic REG_TOP_BIT     = 1'b1;

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_SELECT = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_SEL,
		ST_HOLD
	} state_t;

	// effective (clamped) configuration
	typedef struct packed {
		logic [ADDR_W-1:0] size;
		logic [TOP_W-1:0]  top;
	} cfg_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} stat_t;

endpackage

>>> hw/rtl/fts_engine.sv
// ----------------------------------------------------------------------------
// fts_engine
// Table memory with its clearing pass, update and select walks, result register.
// ----------------------------------------------------------------------------
module fts_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fts_pkg::cfg_t                         cfg,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  req_type,
	input  logic signed [fts_pkg::DATA_W-1:0]     index_or_rank,
	input  logic signed [fts_pkg::DELTA_W-1:0]    delta,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [fts_pkg::SIZE_W-1:0]     found_position,
	output fts_pkg::stat_t                        stat
);
	import fts_pkg::*;

	logic [DATA_W-1:0] mem [TABLE_DEPTH];
	logic [DATA_W-1:0] rdata_q;

	state_t state_q, state_d;

	logic [ADDR_W-1:0]        clr_q;
	logic [WALK_W-1:0]        upd_pos_q;
	logic signed [DELTA_W-1:0] add_q;
	logic [ADDR_W-1:0]        sel_pos_q;
	logic [DATA_W-1:0]        rank_q;
	logic [TOP_W-1:0]         j_q;
	logic [ADDR_W-1:0]        cand_q;
	logic                     cand_ok_q;
	logic                     out_valid_q;
	logic [SIZE_W-1:0]        found_q;

	logic                     rd_en, wr_en, out_load;
	logic [ADDR_W-1:0]        rd_addr, wr_addr;
	logic [DATA_W-1:0]        wr_data;

	logic                     upd_ok, first_ok, upd_more, sel_take, next_ok, out_free;
	logic [ADDR_W-1:0]        first_cand, sel_pos_nxt, next_cand, res_pos;
	logic [WALK_W-1:0]        upd_next;
	logic [TOP_W-1:0]         j_dec;

	always_comb begin
		upd_ok = !index_or_rank[DATA_W-1] && (index_or_rank != '0)
			&& ($unsigned(index_or_rank) <= DATA_W'(cfg.size));
		first_cand = ADDR_W'(1) << cfg.top;
		first_ok   = first_cand <= cfg.size;

		// step to the parent by adding the lowest set bit
		upd_next = upd_pos_q + (upd_pos_q & (~upd_pos_q + WALK_W'(1)));
		upd_more = upd_next <= WALK_W'(cfg.size);

		sel_take    = cand_ok_q && ($signed(rdata_q) < $signed(rank_q));
		sel_pos_nxt = sel_take ? cand_q : sel_pos_q;
		j_dec       = j_q - TOP_W'(1);
		next_cand   = sel_pos_nxt | (ADDR_W'(1) << j_dec);
		next_ok     = next_cand <= cfg.size;

		out_free = !out_valid_q || out_ready;
		res_pos  = (state_q == ST_SEL) ? sel_pos_nxt : sel_pos_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == ADDR_W'(TABLE_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					if (req_type == REQ_SELECT) state_d = ST_SEL;
					else if (upd_ok) state_d = ST_UPD;
				end
			end
			ST_UPD: if (!upd_more) state_d = ST_IDLE;
			ST_SEL: begin
				if (j_q == '0) state_d = out_free ? ST_IDLE : ST_HOLD;
			end
			ST_HOLD: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory port and handshake controls
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (req_type == REQ_SELECT) begin
						rd_en   = first_ok;
						rd_addr = first_cand;
					end else begin
						rd_en   = upd_ok;
						rd_addr = ADDR_W'(index_or_rank);
					end
				end
			end
			ST_UPD: begin
				wr_en   = 1'b1;
				wr_addr = upd_pos_q[ADDR_W-1:0];
				wr_data = rdata_q + DATA_W'(add_q);
				rd_en   = upd_more;
				rd_addr = upd_next[ADDR_W-1:0];
			end
			ST_SEL: begin
				rd_en    = (j_q != '0) && next_ok;
				rd_addr  = next_cand;
				out_load = (j_q == '0) && out_free;
			end
			ST_HOLD: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) found_q <= SIZE_W'({1'b0, res_pos} + WALK_W'(1));
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					upd_pos_q <= WALK_W'(index_or_rank[ADDR_W-1:0]);
					add_q     <= delta;
					sel_pos_q <= '0;
					rank_q    <= index_or_rank;
					j_q       <= cfg.top;
					cand_q    <= first_cand;
					cand_ok_q <= first_ok;
				end
			end
			ST_UPD: upd_pos_q <= upd_next;
			ST_SEL: begin
				sel_pos_q <= sel_pos_nxt;
				if (sel_take) rank_q <= rank_q - rdata_q;
				j_q       <= j_dec;
				cand_q    <= next_cand;
				cand_ok_q <= next_ok;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign found_position = found_q;
	assign stat.clearing  = (state_q == ST_CLEAR);
	assign stat.busy      = (state_q == ST_UPD) || (state_q == ST_SEL) || (state_q == ST_HOLD);

endmodule

>>> hw/rtl/fenwick_tree_rank_select.sv
// ----------------------------------------------------------------------------
// fenwick_tree_rank_select
// Fenwick tree over 32-bit cells: point update and order-statistic select.
// ----------------------------------------------------------------------------
//  channel   | signals                                          | moves
//  ----------+--------------------------------------------------+---------------------
//  request   | in_valid/in_ready, req_type, index_or_rank, delta| one item per request
//  result    | out_valid/out_ready, found_position              | one item per select
//  registers | psel, penable, pwrite, paddr, pwdata, prdata     | active_size, top_bit
//
//  an update reads its first cell, then writes each cell on the upward path
//  while reading the next; a select walks from top_bit, clamped to INDEX_BITS: at most one table
//  read per bit through the single read port, decided in the cycle its data returns
//  after reset a clearing pass zeroes all 2^INDEX_BITS + 1 table entries (1025)
//  with in_ready low; register writes are taken during it
//  a finished select waits in the result register; a full, stalled result
//  register holds the engine before it returns to idle
// ----------------------------------------------------------------------------
module fenwick_tree_rank_select (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic        [fts_pkg::PADDR_W-1:0]    paddr,
	input  logic        [31:0]                    pwdata,
	output logic        [31:0]                    prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  req_type,
	input  logic signed [fts_pkg::DATA_W-1:0]     index_or_rank,
	input  logic signed [fts_pkg::DELTA_W-1:0]    delta,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [fts_pkg::SIZE_W-1:0]     found_position
);
	import fts_pkg::*;

	logic [SIZE_W-1:0] active_size_q;
	logic [TOP_W-1:0]  top_bit_q;
	logic              reg_idx;
	logic              cfg_wr;
	cfg_t              cfg;
	stat_t             stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= ACTIVE_SIZE_RST;
			top_bit_q     <= TOP_BIT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ACTIVE_SIZE: active_size_q <= pwdata[SIZE_W-1:0];
				REG_TOP_BIT:     top_bit_q     <= pwdata[TOP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ACTIVE_SIZE: prdata = 32'(active_size_q);
			REG_TOP_BIT:     prdata = 32'(top_bit_q);
			default:         prdata = '0;
		endcase
	end

	// oversized settings clamp to the table
	always_comb begin
		if (32'(active_size_q) > 32'(SIZE_CAP)) cfg.size = ADDR_W'(SIZE_CAP);
		else cfg.size = ADDR_W'(active_size_q);
		if (32'(top_bit_q) > 32'(INDEX_BITS)) cfg.top = TOP_W'(INDEX_BITS);
		else cfg.top = top_bit_q;
	end

	fts_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.index_or_rank  (index_or_rank),
		.delta          (delta),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found_position (found_position),
		.stat           (stat)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !in_ready)
		else $error("item accepted during table clear");

	a_result_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stat.busy))
		else $error("result without a select in flight");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(found_position) <= int'(cfg.size) + 1))
		else $error("found position beyond active size plus one");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !out_valid)
		else $error("result pending during table clear");

endmodule

>>> dv/fenwick_tree_rank_select_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_tree_rank_select_tb
// Drives point updates and rank selects into the Fenwick tree block under a
// series of size and top-bit settings, and checks every found position
// against a behavioral copy of the tree kept in a scoreboard.
// ----------------------------------------------------------------------------

class tree_scoreboard;

	logic [fts_pkg::DATA_W-1:0] cell_sum [fts_pkg::TABLE_DEPTH];
	logic [fts_pkg::SIZE_W-1:0] active_size;
	logic [fts_pkg::TOP_W-1:0]  top_bit;
	logic [fts_pkg::SIZE_W-1:0] expected_pos [$];
	int unsigned                errors;

	function new();
		foreach (cell_sum[i]) cell_sum[i] = '0;
		active_size = fts_pkg::ACTIVE_SIZE_RST;
		top_bit     = fts_pkg::TOP_BIT_RST;
		errors      = 0;
	endfunction

	function int unsigned eff_size();
		return (active_size > fts_pkg::SIZE_CAP) ? fts_pkg::SIZE_CAP : int'(active_size);
	endfunction

	function int unsigned eff_top();
		return (top_bit > fts_pkg::INDEX_BITS) ? fts_pkg::INDEX_BITS : int'(top_bit);
	endfunction

	function void set_config(logic idx, logic [31:0] value);
		if (idx == fts_pkg::REG_ACTIVE_SIZE)
			active_size = value[fts_pkg::SIZE_W-1:0];
		else
			top_bit = value[fts_pkg::TOP_W-1:0];
	endfunction

	// total of all positions in use (prefix sum up to the active size), as a signed reading
	function int total();
		int unsigned i;
		logic [31:0] acc;
		acc = '0;
		for (i = eff_size(); i > 0; i -= i & (~i + 1))
			acc += cell_sum[i];
		return $signed(acc);
	endfunction

	function void tree_add_delta(logic [31:0] pos_raw, logic [15:0] d);
		int unsigned size;
		int unsigned i;
		logic [31:0] add;
		size = eff_size();
		add  = {{16{d[15]}}, d};
		if ($signed(pos_raw) < 1 || $signed(pos_raw) > int'(size))
			return;
		for (i = pos_raw; i <= size; i += i & (~i + 1))
			cell_sum[i] += add;
	endfunction

	function logic [fts_pkg::SIZE_W-1:0] lift_select(logic [31:0] rank_raw);
		int unsigned size;
		int unsigned pos;
		int unsigned cand;
		logic [31:0] rank;
		size = eff_size();
		pos  = 0;
		rank = rank_raw;
		for (int j = int'(eff_top()); j >= 0; j--) begin
			cand = pos | (1 << j);
			if (cand <= size && $signed(cell_sum[cand]) < $signed(rank)) begin
				rank -= cell_sum[cand];
				pos = cand;
			end
		end
		return fts_pkg::SIZE_W'(pos + 1);
	endfunction

	function void note_request(logic kind, logic [31:0] arg, logic [15:0] d);
		if (kind == fts_pkg::REQ_SELECT)
			expected_pos.push_back(lift_select(arg));
		else
			tree_add_delta(arg, d);
	endfunction

	function void check_position(logic [fts_pkg::SIZE_W-1:0] actual);
		logic [fts_pkg::SIZE_W-1:0] exp_pos;
		if (expected_pos.size() == 0) begin
			$error("found_position: expected none, actual %0d", actual);
			errors++;
			return;
		end
		exp_pos = expected_pos.pop_front();
		if (actual !== exp_pos) begin
			$error("found_position: expected %0d, actual %0d", exp_pos, actual);
			errors++;
		end
	endfunction

	function int unsigned pending();
		return expected_pos.size();
	endfunction

endclass

module fenwick_tree_rank_select_tb;

	import fts_pkg::*;

	localparam int NUM_PHASES = 9;
	localparam int PRESSURE_PHASE = 4;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [PADDR_W-1:0]        paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      in_valid;
	logic                      in_ready;
	logic                      req_type;
	logic signed [DATA_W-1:0]  index_or_rank;
	logic signed [DELTA_W-1:0] delta;
	logic                      out_valid;
	logic                      out_ready;
	logic [SIZE_W-1:0]         found_position;

	bit calm;
	bit long_hold_req;

	tree_scoreboard sb;

	fenwick_tree_rank_select i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.index_or_rank  (index_or_rank),
		.delta          (delta),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found_position (found_position)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// one request item, held until accepted
	task automatic send_item(input logic kind, input logic [31:0] arg, input logic [15:0] d);
		int unsigned gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= kind;
		index_or_rank <= arg;
		delta         <= d;
		do @(posedge clk); while (!in_ready);
		sb.note_request(kind, arg, d);
	endtask

	// drop valid and let the engine drain before touching registers
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_config(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_random(input int unsigned target);
		int unsigned done;
		int unsigned size;
		int          tot;
		logic [31:0] arg;
		logic [15:0] d;
		done = 0;
		size = sb.eff_size();
		while (done < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2:  d = 16'($urandom());
				3:        d = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
				4:        d = 16'(-$urandom_range(1, 20));
				default:  d = 16'($urandom_range(0, 40));
			endcase
			if ($urandom_range(0, 99) < 55) begin
				if (size != 0 && $urandom_range(0, 9) != 0) begin
					arg = $urandom_range(1, size);
				end else begin
					// positions the block must ignore
					case ($urandom_range(0, 3))
						0:       arg = 0;
						1:       arg = size + 1 + $urandom_range(0, 50);
						2:       arg = -$urandom_range(1, 100);
						default: arg = $urandom();
					endcase
				end
				send_item(REQ_UPDATE, arg, d);
				done++;
			end else begin
				case ($urandom_range(0, 9))
					0: arg = $urandom();
					1: begin
						case ($urandom_range(0, 3))
							0:       arg = 32'h8000_0000;
							1:       arg = 32'h7fff_ffff;
							2:       arg = 32'h0;
							default: arg = 32'h1;
						endcase
					end
					default: begin
						tot = sb.total();
						if (tot < 0 || tot > 32'h0fff_ffff)
							tot = 0;
						arg = int'($urandom_range(0, tot + 3)) - 1;
					end
				endcase
				send_item(REQ_SELECT, arg, 16'($urandom()));
				done++;
			end
		end
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_position(found_position);
	end

	initial begin
		int unsigned phase_size [NUM_PHASES];
		int unsigned phase_top  [NUM_PHASES];
		phase_size = '{1024, 1, 0, 2047, 700, 700, 5, 17, 1024};
		phase_top  = '{10, 0, 0, 15, 9, 4, 2, 4, 10};
		sb            = new();
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		req_type      = REQ_UPDATE;
		index_or_rank = '0;
		delta         = '0;
		calm          = 1'b0;
		long_hold_req = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty tree: rank above the total and rank extremes
		send_item(REQ_SELECT, 32'd1, 16'h0);
		send_item(REQ_SELECT, 32'd0, 16'h0);
		send_item(REQ_SELECT, 32'h8000_0000, 16'h0);
		send_item(REQ_SELECT, 32'h7fff_ffff, 16'h0);
		// updates at both ends and with delta extremes
		send_item(REQ_UPDATE, 32'd1, 16'h0001);
		send_item(REQ_UPDATE, 32'd1024, 16'h7fff);
		send_item(REQ_UPDATE, 32'd512, 16'h8000);
		send_item(REQ_UPDATE, 32'd3, 16'hffff);
		send_item(REQ_UPDATE, 32'd700, 16'd100);
		// out of range positions leave the table alone
		send_item(REQ_UPDATE, 32'd0, 16'd55);
		send_item(REQ_UPDATE, 32'd1025, 16'd55);
		send_item(REQ_UPDATE, 32'hffff_ffff, 16'd55);
		send_item(REQ_UPDATE, 32'h7fff_ffff, 16'd55);
		send_item(REQ_UPDATE, 32'h8000_0000, 16'd55);
		send_item(REQ_SELECT, 32'd1, 16'h0);
		send_item(REQ_SELECT, 32'd2, 16'h0);
		send_item(REQ_SELECT, 32'd100, 16'hffff);
		send_item(REQ_SELECT, -32'sd5, 16'h0);
		send_item(REQ_SELECT, 32'h7fff_ffff, 16'h0);
		send_item(REQ_SELECT, 32'h8000_0000, 16'h0);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			apb_write(REG_ACTIVE_SIZE, phase_size[ph]);
			apb_write(REG_TOP_BIT, phase_top[ph]);
			if (ph == PRESSURE_PHASE)
				long_hold_req = 1'b1;
			if (ph == NUM_PHASES - 1)
				calm = 1'b1;
			run_random(180);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
